// ===== hw/rtl/pfdc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfdc_pkg
// Shared types, constants and key square lookup functions for the digraph
// cipher block.
// ----------------------------------------------------------------------------
`default_nettype none

package pfdc_pkg;

  localparam int unsigned Side  = 5;
  localparam int unsigned CodeW = 5;
  localparam int unsigned RowW  = Side * CodeW;
  localparam int unsigned PosW  = 3;
  localparam int unsigned IjW   = 4;
  localparam int unsigned CfgIdxW = 3;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = 1;
  localparam int unsigned QCntW      = 2;

  typedef logic [CodeW-1:0] code_t;
  typedef logic [PosW-1:0]  pos_t;

  localparam code_t FillerCode = 5'd23;
  localparam code_t CodeI      = 5'd8;
  localparam code_t CodeJ      = 5'd9;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegRow0     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRow1     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRow2     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRow3     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRow4     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMergedIj = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDecrypt  = 3'd6;

  localparam logic [RowW-1:0] Row0Reset = 25'd4294688;
  localparam logic [RowW-1:0] Row1Reset = 25'd10755269;
  localparam logic [RowW-1:0] Row2Reset = 25'd16201099;
  localparam logic [RowW-1:0] Row3Reset = 25'd21613104;
  localparam logic [RowW-1:0] Row4Reset = 25'd27025109;
  localparam logic [IjW-1:0]  MergedIjReset = 4'd8;

  typedef struct packed {
    logic [Side-1:0][RowW-1:0] rows;
    logic [IjW-1:0]            merged_ij;
    logic                      decrypt;
  } cfg_t;

  typedef struct packed {
    code_t first;
    code_t second;
    logic  run_end;
    logic  msg_end;
  } pair_t;

  typedef struct packed {
    pos_t row;
    pos_t col;
  } loc_t;

  function automatic code_t cell_at(cfg_t cfg, pos_t r, pos_t c);
    logic [RowW-1:0] row;
    code_t           res;
    case (r)
      3'd1:    row = cfg.rows[1];
      3'd2:    row = cfg.rows[2];
      3'd3:    row = cfg.rows[3];
      3'd4:    row = cfg.rows[4];
      default: row = cfg.rows[0];
    endcase
    case (c)
      3'd1:    res = row[9:5];
      3'd2:    res = row[14:10];
      3'd3:    res = row[19:15];
      3'd4:    res = row[24:20];
      default: res = row[4:0];
    endcase
    return res;
  endfunction

  // first matching cell in row-major order, row 0 column 0 when absent
  function automatic loc_t locate(cfg_t cfg, code_t code);
    code_t key;
    logic  found;
    loc_t  res;
    key = (code == CodeI || code == CodeJ) ? {1'b0, cfg.merged_ij} : code;
    found = 1'b0;
    res = '0;
    for (int i = 0; i < Side; i++) begin
      for (int j = 0; j < Side; j++) begin
        if (!found && cell_at(cfg, pos_t'(i), pos_t'(j)) == key) begin
          found = 1'b1;
          res.row = pos_t'(i);
          res.col = pos_t'(j);
        end
      end
    end
    return res;
  endfunction

  function automatic pos_t shift_pos(pos_t v, logic dec);
    pos_t res;
    if (dec) begin
      res = (v == '0) ? pos_t'(Side - 1) : v - pos_t'(1);
    end else begin
      res = (v == pos_t'(Side - 1)) ? '0 : v + pos_t'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pfdc_front.sv =====
// ----------------------------------------------------------------------------
// pfdc_front
// Takes message letters, tracks the pending letter and forms digraphs with
// filler where needed, one digraph pushed per cycle while the queue has room.
// ----------------------------------------------------------------------------
`default_nettype none

module pfdc_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire pfdc_pkg::code_t in_letter_i,
  input  wire logic            in_final_i,
  output logic                 push_valid_o,
  output pfdc_pkg::pair_t      push_pair_o,
  input  wire logic            push_ready_i
);
  import pfdc_pkg::*;

  logic  pend_valid_q, pend_valid_d;
  code_t pend_code_q, pend_code_d;
  logic  hold_valid_q, hold_valid_d;
  pair_t hold_pair_q, hold_pair_d;
  logic  in_fire;
  logic  gen_valid;
  pair_t gen_pair;
  logic  dup;

  assign in_ready_o = !hold_valid_q && push_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // a repeated letter or an i/j pairing splits with filler
  assign dup = (pend_code_q == in_letter_i) ||
               (pend_code_q == CodeI && in_letter_i == CodeJ) ||
               (pend_code_q == CodeJ && in_letter_i == CodeI);

  always_comb begin
    gen_valid    = 1'b0;
    gen_pair     = '0;
    pend_valid_d = pend_valid_q;
    pend_code_d  = pend_code_q;
    hold_pair_d  = hold_pair_q;
    hold_valid_d = hold_valid_q && !push_ready_i;
    if (in_fire) begin
      if (!pend_valid_q) begin
        if (in_final_i) begin
          gen_valid = 1'b1;
          gen_pair  = '{first: in_letter_i, second: FillerCode, run_end: 1'b1, msg_end: 1'b1};
        end else begin
          pend_valid_d = 1'b1;
          pend_code_d  = in_letter_i;
        end
      end else if (dup) begin
        gen_valid = 1'b1;
        gen_pair  = '{first: pend_code_q, second: FillerCode, run_end: !in_final_i,
                      msg_end: 1'b0};
        if (in_final_i) begin
          hold_valid_d = 1'b1;
          hold_pair_d  = '{first: in_letter_i, second: FillerCode, run_end: 1'b1,
                           msg_end: 1'b1};
          pend_valid_d = 1'b0;
          pend_code_d  = '0;
        end else begin
          pend_code_d = in_letter_i;
        end
      end else begin
        gen_valid    = 1'b1;
        gen_pair     = '{first: pend_code_q, second: in_letter_i, run_end: 1'b1,
                         msg_end: in_final_i};
        pend_valid_d = 1'b0;
        pend_code_d  = '0;
      end
    end
  end

  assign push_valid_o = hold_valid_q || gen_valid;
  assign push_pair_o  = hold_valid_q ? hold_pair_q : gen_pair;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      pend_code_q  <= '0;
      hold_valid_q <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      pend_code_q  <= pend_code_d;
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_pair_q <= hold_pair_d;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pfdc_queue.sv =====
// ----------------------------------------------------------------------------
// pfdc_queue
// Short digraph queue between the pairing front and the substitution back.
// ----------------------------------------------------------------------------
`default_nettype none

module pfdc_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  input  wire pfdc_pkg::pair_t push_pair_i,
  output logic                 push_ready_o,
  output logic                 pop_valid_o,
  output pfdc_pkg::pair_t      pop_pair_o,
  input  wire logic            pop_ready_i
);
  import pfdc_pkg::*;

  pair_t            entries_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != QCntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_pair_o   = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + QCntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_pair_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pfdc_back.sv =====
// ----------------------------------------------------------------------------
// pfdc_back
// Locates each digraph in the key square, applies the row, column or
// rectangle rule and sends out the two letters one per cycle while out_ready_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module pfdc_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire pfdc_pkg::cfg_t  cfg_i,
  input  wire logic            pop_valid_i,
  input  wire pfdc_pkg::pair_t pop_pair_i,
  output logic                 pop_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output pfdc_pkg::code_t      out_letter_o,
  output logic                 run_end_o,
  output logic                 message_end_o
);
  import pfdc_pkg::*;

  // locate stage
  logic  loc_valid_q;
  loc_t  loc_a_q, loc_b_q;
  logic  loc_run_q, loc_msg_q;
  // output register and second letter of the digraph
  logic  out_valid_q, sec_valid_q;
  code_t out_letter_q, sec_letter_q;
  logic  out_run_q, out_msg_q, sec_run_q, sec_msg_q;

  logic  out_fire, pair_load, pop;
  code_t res_a, res_b;

  assign out_fire  = out_valid_q && out_ready_i;
  assign pair_load = loc_valid_q && !sec_valid_q && (!out_valid_q || out_ready_i);
  assign pop_ready_o = !loc_valid_q || pair_load;
  assign pop       = pop_valid_i && pop_ready_o;

  always_comb begin
    if (loc_a_q.row == loc_b_q.row) begin
      res_a = cell_at(cfg_i, loc_a_q.row, shift_pos(loc_a_q.col, cfg_i.decrypt));
      res_b = cell_at(cfg_i, loc_b_q.row, shift_pos(loc_b_q.col, cfg_i.decrypt));
    end else if (loc_a_q.col == loc_b_q.col) begin
      res_a = cell_at(cfg_i, shift_pos(loc_a_q.row, cfg_i.decrypt), loc_a_q.col);
      res_b = cell_at(cfg_i, shift_pos(loc_b_q.row, cfg_i.decrypt), loc_b_q.col);
    end else begin
      res_a = cell_at(cfg_i, loc_a_q.row, loc_b_q.col);
      res_b = cell_at(cfg_i, loc_b_q.row, loc_a_q.col);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loc_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      sec_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        loc_valid_q <= 1'b1;
      end else if (pair_load) begin
        loc_valid_q <= 1'b0;
      end
      if (pair_load) begin
        out_valid_q <= 1'b1;
        sec_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= sec_valid_q;
        sec_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      loc_a_q   <= locate(cfg_i, pop_pair_i.first);
      loc_b_q   <= locate(cfg_i, pop_pair_i.second);
      loc_run_q <= pop_pair_i.run_end;
      loc_msg_q <= pop_pair_i.msg_end;
    end
    if (pair_load) begin
      out_letter_q <= res_a;
      out_run_q    <= 1'b0;
      out_msg_q    <= 1'b0;
      sec_letter_q <= res_b;
      sec_run_q    <= loc_run_q;
      sec_msg_q    <= loc_msg_q;
    end else if (out_fire) begin
      out_letter_q <= sec_letter_q;
      out_run_q    <= sec_run_q;
      out_msg_q    <= sec_msg_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_letter_o  = out_letter_q;
  assign run_end_o     = out_run_q;
  assign message_end_o = out_msg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/playfair_digraph_cipher_top.sv =====
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_top
// Playfair digraph cipher over a configurable 5x5 key square.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries one letter code per item with
// a flag on the last letter of the message. Output channel
// (out_valid_o/out_ready_i) carries substituted letters, two per digraph,
// with run_end_o on the last letter caused by an input item and
// message_end_o on the last letter of the message.
// The user must write key square rows, the merged i/j code and the decrypt
// mode on the cfg port only while the block is idle, unenforced by the block;
// reset loads the default square. A digraph passes from the queue through
// the locate stage into the output register, which sends its first letter
// and then its second; the output register sends one letter per cycle while
// out_ready_i is high. An item giving two digraphs holds in_ready_o low
// while its second digraph waits in the hold register to enter the queue.
// Reset clears the pending letter, the queue and all output state.
// When the receiver stalls, the two-entry digraph queue and the locate stage
// fill, after which in_ready_o drops.
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_digraph_cipher_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [2:0]                cfg_idx_i,
  input  wire logic [24:0]               cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [4:0]                in_letter_i,
  input  wire logic                      in_final_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [4:0]                     out_letter_o,
  output logic                           run_end_o,
  output logic                           message_end_o
);
  import pfdc_pkg::*;

  cfg_t  cfg_q;
  logic  push_valid, push_ready, pop_valid, pop_ready;
  pair_t push_pair, pop_pair;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows[0]  <= Row0Reset;
      cfg_q.rows[1]  <= Row1Reset;
      cfg_q.rows[2]  <= Row2Reset;
      cfg_q.rows[3]  <= Row3Reset;
      cfg_q.rows[4]  <= Row4Reset;
      cfg_q.merged_ij <= MergedIjReset;
      cfg_q.decrypt  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRow0:     cfg_q.rows[0]   <= cfg_wdata_i;
        RegRow1:     cfg_q.rows[1]   <= cfg_wdata_i;
        RegRow2:     cfg_q.rows[2]   <= cfg_wdata_i;
        RegRow3:     cfg_q.rows[3]   <= cfg_wdata_i;
        RegRow4:     cfg_q.rows[4]   <= cfg_wdata_i;
        RegMergedIj: cfg_q.merged_ij <= cfg_wdata_i[IjW-1:0];
        RegDecrypt:  cfg_q.decrypt   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  pfdc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_letter_i  (in_letter_i),
    .in_final_i   (in_final_i),
    .push_valid_o (push_valid),
    .push_pair_o  (push_pair),
    .push_ready_i (push_ready)
  );

  pfdc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_pair_i  (push_pair),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_pair_o   (pop_pair),
    .pop_ready_i  (pop_ready)
  );

  pfdc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .pop_valid_i   (pop_valid),
    .pop_pair_i    (pop_pair),
    .pop_ready_o   (pop_ready),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_letter_o  (out_letter_o),
    .run_end_o     (run_end_o),
    .message_end_o (message_end_o)
  );

endmodule

`default_nettype wire
